// ----- src/success_count_distribution_assert.svh -----
// Assertion macros for the success count distribution block.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef SUCCESS_COUNT_DISTRIBUTION_ASSERT_SVH
`define SUCCESS_COUNT_DISTRIBUTION_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication check, disabled while reset is low
`define SCD_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scd: assertion failed");
// Next-cycle implication check, disabled while reset is low
`define SCD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scd: assertion failed");
`else
`define SCD_ASSERT(lbl, clk, rstn, ante, cons)
`define SCD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/scd_pkg.sv -----
// Shared types and constants of the success count distribution block.
// Used by scd_mac and success_count_distribution; depends on nothing.
`default_nettype none

package scd_pkg;

    localparam int PROB_W  = 17;
    localparam int FRAC_W  = 16;
    localparam int COUNT_W = 6;

    typedef logic [PROB_W-1:0]  prob_t;
    typedef logic [COUNT_W-1:0] count_t;

    // 1.0 in unsigned Q1.16
    localparam prob_t ONE_Q16 = 17'h10000;

    // One input transaction
    typedef struct packed {
        prob_t success_prob;
        logic  last_prob;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        count_t success_count;
        prob_t  count_prob;
        logic   final_entry;
        logic   overflow;
    } out_item_t;

    // Control into the multiply-add unit
    typedef struct packed {
        logic valid;
        logic start;
    } mac_ctl_t;

    // Result of the multiply-add unit, one store entry
    typedef struct packed {
        logic  valid;
        prob_t value;
    } mac_res_t;

endpackage

`default_nettype wire

// ----- src/scd_mac.sv -----
// Two-stage multiply-add unit: new = trunc(r*p) + trunc(prev*(1-p)), saturated to 1.0.
// Depends on scd_pkg for the Q1.16 types and control structs.
`default_nettype none

module scd_mac (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire scd_pkg::mac_ctl_t ctl,
    input  wire scd_pkg::prob_t   rd_value,
    input  wire scd_pkg::prob_t   prob,
    output scd_pkg::mac_res_t     res
);

    localparam int PW = scd_pkg::PROB_W;
    localparam int FW = scd_pkg::FRAC_W;

    scd_pkg::prob_t     q;
    scd_pkg::prob_t     stay_in;
    logic [2*PW-1:0]    prod_up;
    logic [2*PW-1:0]    prod_stay;
    logic [PW:0]        sum;

    scd_pkg::prob_t     prev_reg;
    scd_pkg::prob_t     prev_next;
    logic               s1_valid_reg;
    scd_pkg::prob_t     up_reg;
    scd_pkg::prob_t     stay_reg;
    logic               out_valid_reg;
    scd_pkg::prob_t     out_value_reg;
    scd_pkg::prob_t     out_value_next;

    // Form both truncated products; the carried entry is zero at the top of a walk
    always_comb begin
        q         = scd_pkg::ONE_Q16 - prob;
        stay_in   = ctl.start ? '0 : prev_reg;
        prod_up   = {{PW{1'b0}}, rd_value} * {{PW{1'b0}}, prob};
        prod_stay = {{PW{1'b0}}, stay_in} * {{PW{1'b0}}, q};
        prev_next = ctl.valid ? rd_value : prev_reg;
    end

    // Add the two terms and clamp to 1.0
    always_comb begin
        sum            = {1'b0, up_reg} + {1'b0, stay_reg};
        out_value_next = (sum > {1'b0, scd_pkg::ONE_Q16}) ? scd_pkg::ONE_Q16 : sum[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= ctl.valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload stages, no reset
    always_ff @(posedge aclk) begin
        prev_reg      <= prev_next;
        up_reg        <= prod_up[FW+PW-1:FW];
        stay_reg      <= prod_stay[FW+PW-1:FW];
        out_value_reg <= out_value_next;
    end

    assign res.valid = out_valid_reg;
    assign res.value = out_value_reg;

endmodule

`default_nettype wire

// ----- src/success_count_distribution.sv -----
// Top level of the success count distribution block: store, sequencer and output register.
// Depends on scd_pkg, scd_mac and success_count_distribution_assert.svh.
//
// Each accepted probability (Q1.16, values above 1.0 clamped) folds one more independent
// trial into the stored distribution of the success count. The store is a single
// synchronous memory of MAX_ITEMS+1 entries with one read and one write port; an update
// walks it from the highest live entry down to entry 0, reading one entry a cycle,
// feeding the two-stage multiply-add unit and writing back behind the reads. The next
// transaction is accepted only once the update has written entry 0. A probability arriving
// at full capacity is dropped without a walk and raises overflow for the set. With n
// probabilities held, a transaction marked last makes the block send entries 0 to n, one
// per cycle while m_ready is held, with final_entry on entry n, and then start a fresh set.
// No clearing pass is needed after reset or between sets: entries above the held count
// are never read.
`default_nettype none

`include "success_count_distribution_assert.svh"

module success_count_distribution #(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire scd_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output scd_pkg::out_item_t      m_data
);

    localparam int DEPTH = MAX_ITEMS + 1;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    // Store
    scd_pkg::prob_t     mem [DEPTH];
    scd_pkg::prob_t     rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;

    // Control state
    logic [1:0]         state_reg,       state_next;
    logic [AW-1:0]      items_loaded_reg, items_loaded_next;
    logic               dropped_reg,     dropped_next;
    logic               iss_run_reg,     iss_run_next;
    logic               zero_pend_reg,   zero_pend_next;
    logic               tag_valid_reg,   tag_valid_next;
    logic               rd_pend_reg,     rd_pend_next;
    logic               emit_done_reg,   emit_done_next;
    logic               m_valid_reg,     m_valid_next;

    // Payload state
    scd_pkg::prob_t     p_reg,           p_next;
    logic               last_reg,        last_next;
    logic [AW-1:0]      iss_addr_reg,    iss_addr_next;
    logic [AW-1:0]      wr_addr_reg,     wr_addr_next;
    logic [AW-1:0]      emit_addr_reg,   emit_addr_next;
    logic               tag_start_reg,   tag_start_next;
    logic               tag_zero_reg,    tag_zero_next;
    logic               rd_init_reg,     rd_init_next;
    logic [AW-1:0]      em_idx_reg,      em_idx_next;
    logic               em_final_reg,    em_final_next;
    scd_pkg::out_item_t m_data_reg,      m_data_next;

    logic               s_accept;
    logic               emit_load;
    logic               emit_issue;
    scd_pkg::prob_t     p_sat;
    scd_pkg::prob_t     rd_value;
    scd_pkg::mac_ctl_t  mac_ctl;
    scd_pkg::mac_res_t  mac_res;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign p_sat    = (s_data.success_prob > scd_pkg::ONE_Q16) ? scd_pkg::ONE_Q16
                                                               : s_data.success_prob;

    // Entry 0 of a fresh set reads as 1.0; the extra bottom step feeds zero
    always_comb begin
        if (tag_zero_reg) begin
            rd_value = '0;
        end else if (rd_init_reg) begin
            rd_value = scd_pkg::ONE_Q16;
        end else begin
            rd_value = rd_data_reg;
        end
    end

    assign mac_ctl.valid = tag_valid_reg;
    assign mac_ctl.start = tag_start_reg;
    assign mem_we        = mac_res.valid;

    scd_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .rd_value (rd_value),
        .prob     (p_reg),
        .res      (mac_res)
    );

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        items_loaded_next = items_loaded_reg;
        dropped_next      = dropped_reg;
        iss_run_next      = iss_run_reg;
        zero_pend_next    = zero_pend_reg;
        tag_valid_next    = 1'b0;
        rd_pend_next      = rd_pend_reg;
        emit_done_next    = emit_done_reg;
        m_valid_next      = m_valid_reg;
        p_next            = p_reg;
        last_next         = last_reg;
        iss_addr_next     = iss_addr_reg;
        wr_addr_next      = wr_addr_reg;
        emit_addr_next    = emit_addr_reg;
        tag_start_next    = tag_start_reg;
        tag_zero_next     = tag_zero_reg;
        rd_init_next      = rd_init_reg;
        em_idx_next       = em_idx_reg;
        em_final_next     = em_final_reg;
        m_data_next       = m_data_reg;
        rd_en             = 1'b0;
        rd_addr           = iss_addr_reg;
        emit_load         = 1'b0;
        emit_issue        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // Take a probability: walk the store, or drop it at capacity
                if (s_accept) begin
                    p_next         = p_sat;
                    last_next      = s_data.last_prob;
                    emit_addr_next = '0;
                    emit_done_next = 1'b0;
                    rd_pend_next   = 1'b0;
                    if (items_loaded_reg == AW'(MAX_ITEMS)) begin
                        dropped_next = 1'b1;
                        if (s_data.last_prob) begin
                            state_next = ST_EMIT;
                        end
                    end else begin
                        state_next    = ST_UPDATE;
                        iss_run_next  = 1'b1;
                        iss_addr_next = items_loaded_reg;
                        wr_addr_next  = items_loaded_reg + AW'(1);
                    end
                end
            end
            ST_UPDATE: begin
                // Issue reads top down, then one zero step for entry 0
                if (iss_run_reg) begin
                    rd_en          = 1'b1;
                    rd_addr        = iss_addr_reg;
                    tag_valid_next = 1'b1;
                    tag_start_next = (iss_addr_reg == items_loaded_reg);
                    tag_zero_next  = 1'b0;
                    rd_init_next   = (items_loaded_reg == '0);
                    if (iss_addr_reg == '0) begin
                        iss_run_next   = 1'b0;
                        zero_pend_next = 1'b1;
                    end else begin
                        iss_addr_next = iss_addr_reg - AW'(1);
                    end
                end else if (zero_pend_reg) begin
                    tag_valid_next = 1'b1;
                    tag_start_next = 1'b0;
                    tag_zero_next  = 1'b1;
                    zero_pend_next = 1'b0;
                end
                // Write back behind the reads; finish on entry 0
                if (mac_res.valid) begin
                    wr_addr_next = wr_addr_reg - AW'(1);
                    if (wr_addr_reg == '0) begin
                        items_loaded_next = items_loaded_reg + AW'(1);
                        state_next        = last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                // Move a read result into the output register when it is free
                emit_load  = rd_pend_reg && (!m_valid_reg || m_ready);
                emit_issue = !emit_done_reg && (!rd_pend_reg || emit_load);
                if (emit_load) begin
                    m_valid_next              = 1'b1;
                    m_data_next.success_count = scd_pkg::count_t'(em_idx_reg);
                    m_data_next.count_prob    = rd_init_reg ? scd_pkg::ONE_Q16 : rd_data_reg;
                    m_data_next.final_entry   = em_final_reg;
                    m_data_next.overflow      = dropped_reg;
                end else if (m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (emit_issue) begin
                    rd_en         = 1'b1;
                    rd_addr       = emit_addr_reg;
                    rd_pend_next  = 1'b1;
                    rd_init_next  = (items_loaded_reg == '0);
                    em_idx_next   = emit_addr_reg;
                    em_final_next = (emit_addr_reg == items_loaded_reg);
                    if (emit_addr_reg == items_loaded_reg) begin
                        emit_done_next = 1'b1;
                    end else begin
                        emit_addr_next = emit_addr_reg + AW'(1);
                    end
                end else if (emit_load) begin
                    rd_pend_next = 1'b0;
                end
                // Final entry taken: start a fresh set
                if (m_valid_reg && m_ready && m_data_reg.final_entry) begin
                    items_loaded_next = '0;
                    dropped_next      = 1'b0;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr_reg] <= mac_res.value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            items_loaded_reg <= '0;
            dropped_reg      <= 1'b0;
            iss_run_reg      <= 1'b0;
            zero_pend_reg    <= 1'b0;
            tag_valid_reg    <= 1'b0;
            rd_pend_reg      <= 1'b0;
            emit_done_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            items_loaded_reg <= items_loaded_next;
            dropped_reg      <= dropped_next;
            iss_run_reg      <= iss_run_next;
            zero_pend_reg    <= zero_pend_next;
            tag_valid_reg    <= tag_valid_next;
            rd_pend_reg      <= rd_pend_next;
            emit_done_reg    <= emit_done_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        p_reg         <= p_next;
        last_reg      <= last_next;
        iss_addr_reg  <= iss_addr_next;
        wr_addr_reg   <= wr_addr_next;
        emit_addr_reg <= emit_addr_next;
        tag_start_reg <= tag_start_next;
        tag_zero_reg  <= tag_zero_next;
        rd_init_reg   <= rd_init_next;
        em_idx_reg    <= em_idx_next;
        em_final_reg  <= em_final_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `SCD_ASSERT(a_out_only_emit, aclk, aresetn, m_valid, state_reg == ST_EMIT)
    `SCD_ASSERT(a_wr_only_update, aclk, aresetn, mac_res.valid, state_reg == ST_UPDATE)
    `SCD_ASSERT(a_count_cap, aclk, aresetn, 1'b1, items_loaded_reg <= AW'(MAX_ITEMS))
    `SCD_ASSERT(a_final_idx, aclk, aresetn, m_valid && m_data.final_entry, m_data.success_count == scd_pkg::count_t'(items_loaded_reg))
    `SCD_ASSERT_NXT(a_wr_unbroken, aclk, aresetn, mac_res.valid && (wr_addr_reg != '0), mac_res.valid)

endmodule

`default_nettype wire
